[hdl/plt_pkg.sv]
`default_nettype none

package plt_pkg;

  // packet type codes
  localparam logic [7:0] PKT_SIZES = 8'd1;
  localparam logic [7:0] PKT_TRANS = 8'd2;
  localparam logic [7:0] PKT_RECS  = 8'd3;
  localparam logic [7:0] PKT_START = 8'd254;
  localparam logic [7:0] PKT_END   = 8'd255;

  // packet and record geometry
  localparam int unsigned PACKET_BYTES  = 16;
  localparam int unsigned PAYLOAD_BYTES = PACKET_BYTES - 2;
  localparam int unsigned RECORD_BYTES  = 6;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int unsigned RECORD_W      = 8 * RECORD_BYTES;

  // lookup index: 8-bit event plus 7-bit state times 8-bit event count
  localparam int unsigned IDX_W      = 15;
  // record byte address: 7-bit state times record size plus offset
  localparam int unsigned REC_ADDR_W = 10;

  localparam logic [15:0] SEQ_RESET = 16'd1;
  localparam logic [8:0]  NONE9     = 9'h1FF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WR_TRANS,
    ST_WR_REC,
    ST_INDEX,
    ST_TREAD,
    ST_TCHECK,
    ST_REC,
    ST_FINISH
  } plt_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic arm;
    logic start;
    logic sizes;
    logic adv_seq;
    logic wr_trans;
    logic wr_rec;
    logic calc_idx;
    logic move;
    logic rec_step;
    logic emit;
  } plt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode;
    logic type_end;
    logic type_start;
    logic type_sizes;
    logic type_trans;
    logic type_recs;
    logic seq_ok;
    logic armed;
    logic idx_ok;
    logic nxt_ok;
    logic wr_last;
    logic rec_last;
    logic out_free;
  } plt_status_t;

endpackage

`default_nettype wire

[hdl/plt_ram.sv]
`default_nettype none

module plt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/plt_ctrl.sv]
`default_nettype none

module plt_ctrl
  import plt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire plt_status_t status_i,
  output plt_cmd_t         cmd_o
);

  plt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.mode) begin
          state_d = status_i.armed ? ST_INDEX : ST_FINISH;
        end else if (status_i.type_end) begin
          cmd_o.arm = 1'b1;
          state_d   = ST_FINISH;
        end else if (status_i.type_start) begin
          cmd_o.start = 1'b1;
          state_d     = ST_FINISH;
        end else if (status_i.seq_ok && status_i.type_sizes) begin
          cmd_o.sizes   = 1'b1;
          cmd_o.adv_seq = 1'b1;
          state_d       = ST_FINISH;
        end else if (status_i.seq_ok && status_i.type_trans) begin
          cmd_o.adv_seq = 1'b1;
          state_d       = ST_WR_TRANS;
        end else if (status_i.seq_ok && status_i.type_recs) begin
          cmd_o.adv_seq = 1'b1;
          state_d       = ST_WR_REC;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WR_TRANS: begin
        cmd_o.wr_trans = 1'b1;
        if (status_i.wr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_WR_REC: begin
        cmd_o.wr_rec = 1'b1;
        if (status_i.wr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_INDEX: begin
        cmd_o.calc_idx = 1'b1;
        state_d        = ST_TREAD;
      end
      ST_TREAD: begin
        state_d = status_i.idx_ok ? ST_TCHECK : ST_FINISH;
      end
      ST_TCHECK: begin
        if (status_i.nxt_ok) begin
          cmd_o.move = 1'b1;
          state_d    = ST_REC;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_REC: begin
        cmd_o.rec_step = 1'b1;
        if (status_i.rec_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/plt_dp.sv]
`default_nettype none

module plt_dp
  import plt_pkg::*;
#(
  parameter int unsigned TRANSITION_DEPTH = 4096,
  parameter int unsigned RECORD_DEPTH     = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire plt_cmd_t             cmd_i,
  output plt_status_t               status_o,
  input  wire logic                 mode_i,
  input  wire logic [7:0]           packet_seq_i,
  input  wire logic [7:0]           packet_type_i,
  input  wire logic [55:0]          payload_low_i,
  input  wire logic [55:0]          payload_high_i,
  input  wire logic [7:0]           event_code_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      load_done_o,
  output logic                      start_seen_o,
  output logic                      moved_o,
  output logic signed [8:0]         record_state_num_o,
  output logic signed [8:0]         record_action_num_o,
  output logic [7:0]                record_value_a_o,
  output logic [7:0]                record_value_b_o,
  output logic [7:0]                record_value_c_o,
  output logic [7:0]                record_value_d_o
);

  localparam int unsigned TAW = $clog2(TRANSITION_DEPTH);
  localparam int unsigned TFW = $clog2(TRANSITION_DEPTH + 1);
  localparam int unsigned ICW = (TFW > IDX_W) ? TFW : IDX_W;
  localparam int unsigned RAW = $clog2(RECORD_DEPTH);
  localparam int unsigned RFW = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned RCW = (RFW > REC_ADDR_W) ? RFW : REC_ADDR_W;

  // captured item
  logic                 mode_q;
  logic [7:0]           seq_q;
  logic [7:0]           type_q;
  logic [7:0]           ev_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic [3:0]           wr_cnt_q;

  // table state
  logic [15:0]    exp_seq_q;
  logic [TFW-1:0] t_fill_q;
  logic [RFW-1:0] r_fill_q;
  logic [7:0]     event_count_q;
  logic [6:0]     present_q;
  logic           armed_q;

  // lookup working registers
  logic [IDX_W-1:0]      idx_q;
  logic [REC_ADDR_W-1:0] base_q;
  logic [2:0]            rec_cnt_q;
  logic                  inr_q;
  logic [RECORD_W-1:0]   recsh_q;

  // result flags of the item at work
  logic res_done_q;
  logic res_start_q;
  logic res_moved_q;

  // output register
  logic             out_valid_q;
  logic             out_done_q;
  logic             out_start_q;
  logic             out_moved_q;
  logic [8:0]       out_state_num_q;
  logic [8:0]       out_action_num_q;
  logic [7:0]       out_a_q;
  logic [7:0]       out_b_q;
  logic [7:0]       out_c_q;
  logic [7:0]       out_d_q;

  logic           t_we;
  logic           r_we;
  logic [7:0]     t_rdata;
  logic [7:0]     r_rdata;
  logic [RCW-1:0] rec_addr;
  logic           out_free;

  // store append enables, dropped once a store is full
  assign t_we = cmd_i.wr_trans && (t_fill_q < TFW'(TRANSITION_DEPTH));
  assign r_we = cmd_i.wr_rec && (r_fill_q < RFW'(RECORD_DEPTH));

  assign rec_addr = RCW'(base_q) + RCW'(rec_cnt_q);
  assign out_free = !out_valid_q || out_ready_i;

  // status back to the controller
  always_comb begin
    status_o            = '0;
    status_o.mode       = mode_q;
    status_o.type_end   = (type_q == PKT_END);
    status_o.type_start = (type_q == PKT_START);
    status_o.type_sizes = (type_q == PKT_SIZES);
    status_o.type_trans = (type_q == PKT_TRANS);
    status_o.type_recs  = (type_q == PKT_RECS);
    status_o.seq_ok     = (exp_seq_q == {8'h00, seq_q});
    status_o.armed      = armed_q;
    status_o.idx_ok     = (ICW'(idx_q) < ICW'(t_fill_q));
    status_o.nxt_ok     = !t_rdata[7];
    status_o.wr_last    = (wr_cnt_q == 4'(PAYLOAD_BYTES - 1));
    status_o.rec_last   = (rec_cnt_q == 3'(RECORD_BYTES));
    status_o.out_free   = out_free;
  end

  // item capture and payload byte shifter
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      seq_q  <= packet_seq_i;
      type_q <= packet_type_i;
      ev_q   <= event_code_i;
      pay_q  <= {payload_high_i, payload_low_i};
    end else if (cmd_i.wr_trans || cmd_i.wr_rec) begin
      pay_q <= {8'h00, pay_q[PAYLOAD_W-1:8]};
    end
  end

  // control state: sequence, fills, sizes, present state, result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q      <= '0;
      exp_seq_q     <= SEQ_RESET;
      t_fill_q      <= '0;
      r_fill_q      <= '0;
      event_count_q <= '0;
      present_q     <= '0;
      armed_q       <= 1'b0;
      rec_cnt_q     <= '0;
      res_done_q    <= 1'b0;
      res_start_q   <= 1'b0;
      res_moved_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        wr_cnt_q    <= '0;
        res_done_q  <= 1'b0;
        res_start_q <= 1'b0;
        res_moved_q <= 1'b0;
      end
      if (cmd_i.wr_trans || cmd_i.wr_rec) begin
        wr_cnt_q <= wr_cnt_q + 4'd1;
      end
      if (cmd_i.adv_seq) begin
        exp_seq_q <= exp_seq_q + 16'd1;
      end
      if (cmd_i.sizes) begin
        event_count_q <= pay_q[15:8];
      end
      if (t_we) begin
        t_fill_q <= t_fill_q + TFW'(1);
      end
      if (r_we) begin
        r_fill_q <= r_fill_q + RFW'(1);
      end
      if (cmd_i.arm) begin
        armed_q    <= 1'b1;
        present_q  <= '0;
        res_done_q <= 1'b1;
      end
      if (cmd_i.start) begin
        res_start_q <= 1'b1;
      end
      if (cmd_i.move) begin
        present_q   <= t_rdata[6:0];
        res_moved_q <= 1'b1;
        rec_cnt_q   <= '0;
      end else if (cmd_i.rec_step && !status_o.rec_last) begin
        rec_cnt_q <= rec_cnt_q + 3'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // index compute, record base and record byte gathering
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_idx) begin
      idx_q <= IDX_W'(ev_q) + IDX_W'(present_q) * IDX_W'(event_count_q);
    end
    if (cmd_i.move) begin
      base_q <= REC_ADDR_W'(t_rdata[6:0]) * REC_ADDR_W'(RECORD_BYTES);
    end
    if (cmd_i.rec_step) begin
      inr_q <= (rec_addr < RCW'(r_fill_q));
      if (rec_cnt_q != 3'd0) begin
        recsh_q <= {(inr_q ? r_rdata : 8'h00), recsh_q[RECORD_W-1:8]};
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_done_q  <= res_done_q;
      out_start_q <= res_start_q;
      out_moved_q <= res_moved_q;
      if (res_moved_q) begin
        out_state_num_q  <= {1'b0, recsh_q[7:0]};
        out_action_num_q <= {1'b0, recsh_q[15:8]};
        out_a_q          <= recsh_q[23:16];
        out_b_q          <= recsh_q[31:24];
        out_c_q          <= recsh_q[39:32];
        out_d_q          <= recsh_q[47:40];
      end else begin
        out_state_num_q  <= NONE9;
        out_action_num_q <= NONE9;
        out_a_q          <= 8'h00;
        out_b_q          <= 8'h00;
        out_c_q          <= 8'h00;
        out_d_q          <= 8'h00;
      end
    end
  end

  // transition table
  plt_ram #(
    .WIDTH (8),
    .DEPTH (TRANSITION_DEPTH)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_fill_q[TAW-1:0]),
    .wdata_i (pay_q[7:0]),
    .raddr_i (TAW'(idx_q)),
    .rdata_o (t_rdata)
  );

  // state record table
  plt_ram #(
    .WIDTH (8),
    .DEPTH (RECORD_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_fill_q[RAW-1:0]),
    .wdata_i (pay_q[7:0]),
    .raddr_i (rec_addr[RAW-1:0]),
    .rdata_o (r_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign load_done_o         = out_done_q;
  assign start_seen_o        = out_start_q;
  assign moved_o             = out_moved_q;
  assign record_state_num_o  = out_state_num_q;
  assign record_action_num_o = out_action_num_q;
  assign record_value_a_o    = out_a_q;
  assign record_value_b_o    = out_b_q;
  assign record_value_c_o    = out_c_q;
  assign record_value_d_o    = out_d_q;

`ifndef SYNTHESIS
  a_tfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_fill_q <= TFW'(TRANSITION_DEPTH))
    else $error("transition fill past depth");

  a_rfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_fill_q <= RFW'(RECORD_DEPTH))
    else $error("record fill past depth");

  a_seq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_seq_q <= 16'd256)
    else $error("expected sequence advanced without a matching byte");

  a_moved_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_moved_q |-> !out_done_q && !out_start_q)
    else $error("move result also flags a packet");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted result not presented");
`endif

endmodule

`default_nettype wire

[hdl/packet_loaded_table_fsm.sv]
`default_nettype none

// Programmable table-driven state machine loaded from 16-byte packets. One
// item is taken at a time: the input is ready only while the controller is
// idle, and the finished result sits in an output register so the next item
// can be taken while it waits. A sizing, start, end, out-of-sequence or
// unknown packet goes from decode straight to the finish state; a transition
// or record packet has its payload appended one byte per cycle through the
// single write port of its table memory, bytes past a full table being
// dropped; an event goes straight to finish before arming, else it runs the
// index multiply-add, then the registered transition table read, and for a
// move gathers the six record bytes one per cycle from the record memory's
// read port. The output register is loaded once the output side is free, and
// the input is ready again in the cycle after it is loaded. Both tables start
// empty after reset; fill counters mark the written part, so there is no
// clearing pass. Record bytes never written read as zero.
module packet_loaded_table_fsm
  import plt_pkg::*;
#(
  parameter int unsigned TRANSITION_DEPTH = 4096,
  parameter int unsigned RECORD_DEPTH     = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input transfer
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // packet_seq, packet_type, payload_low, payload_high, event_code
  input  wire logic [135:0] s_axis_tdata_i,
  // mode
  input  wire logic         s_axis_tuser_i,
  // result transfer
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // record state number, record action number, record_value_a..d, zero fill
  output logic [55:0]       m_axis_tdata_o,
  // load_done, start_seen, moved
  output logic [2:0]        m_axis_tuser_o
);

  plt_cmd_t    cmd;
  plt_status_t status;

  logic              load_done;
  logic              start_seen;
  logic              moved;
  logic signed [8:0] record_state_num;
  logic signed [8:0] record_action_num;
  logic [7:0]        record_value_a;
  logic [7:0]        record_value_b;
  logic [7:0]        record_value_c;
  logic [7:0]        record_value_d;

  // controller
  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath with both table memories
  plt_dp #(
    .TRANSITION_DEPTH (TRANSITION_DEPTH),
    .RECORD_DEPTH     (RECORD_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .mode_i              (s_axis_tuser_i),
    .packet_seq_i        (s_axis_tdata_i[7:0]),
    .packet_type_i       (s_axis_tdata_i[15:8]),
    .payload_low_i       (s_axis_tdata_i[71:16]),
    .payload_high_i      (s_axis_tdata_i[127:72]),
    .event_code_i        (s_axis_tdata_i[135:128]),
    .out_ready_i         (m_axis_tready_i),
    .out_valid_o         (m_axis_tvalid_o),
    .load_done_o         (load_done),
    .start_seen_o        (start_seen),
    .moved_o             (moved),
    .record_state_num_o  (record_state_num),
    .record_action_num_o (record_action_num),
    .record_value_a_o    (record_value_a),
    .record_value_b_o    (record_value_b),
    .record_value_c_o    (record_value_c),
    .record_value_d_o    (record_value_d)
  );

  // result packing
  assign m_axis_tdata_o = {6'd0, record_value_d, record_value_c, record_value_b,
                           record_value_a, record_action_num, record_state_num};
  assign m_axis_tuser_o = {moved, start_seen, load_done};

endmodule

`default_nettype wire
